[design/quad_fit_peak_offset_3d_macros.svh]
// assertion macros for the quadratic peak fit block
// expects a clock named clk and an active-low synchronous reset named rst_n in scope
`ifndef QUAD_FIT_PEAK_OFFSET_3D_MACROS_SVH
`define QUAD_FIT_PEAK_OFFSET_3D_MACROS_SVH

// same-cycle implication
`define QFPO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QFPO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/qfpo_pkg.sv]
// shared constants, types and the multiply sequence table for the peak fit
// no dependencies
package qfpo_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OFF_FRAC    = 12;
  localparam int NPOS        = 27;
  localparam int ADDR_W      = 5;
  localparam int SUM_W       = 20;
  localparam int CRN_W       = 18;
  localparam int H_W         = 24;
  localparam int ADJ_W       = 48;
  localparam int SEG_W       = 24;
  localparam int ACC_W       = 76;
  localparam int Q_W         = 16;
  localparam int DIV_W       = ACC_W + Q_W;
  localparam int CNT_W       = 5;
  localparam int DET_FRAC    = 30;
  localparam int DET_SCALE   = 46656;
  localparam int DMIN_W      = 32;
  localparam int DSC_W       = 48;
  localparam int LIM_W       = 15;
  localparam int NSTEP       = 36;
  localparam int STEP_W      = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_NEG   = 2'd1;
  localparam logic [1:0] ST_DET_SMALL = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DET_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_LIMIT = 2'd1;

  // small operands: hessian and gradient, all scaled by 36
  localparam logic [3:0] OP_HUU = 4'd0;
  localparam logic [3:0] OP_HVV = 4'd1;
  localparam logic [3:0] OP_HWW = 4'd2;
  localparam logic [3:0] OP_HUV = 4'd3;
  localparam logic [3:0] OP_HUW = 4'd4;
  localparam logic [3:0] OP_HVW = 4'd5;
  localparam logic [3:0] OP_GU  = 4'd6;
  localparam logic [3:0] OP_GV  = 4'd7;
  localparam logic [3:0] OP_GW  = 4'd8;
  localparam int NOPND = 9;

  // adjugate entries
  localparam logic [2:0] AD_00 = 3'd0;
  localparam logic [2:0] AD_01 = 3'd1;
  localparam logic [2:0] AD_02 = 3'd2;
  localparam logic [2:0] AD_11 = 3'd3;
  localparam logic [2:0] AD_12 = 3'd4;
  localparam logic [2:0] AD_22 = 3'd5;
  localparam int NADJ = 6;

  localparam logic [1:0] Y_SMALL = 2'd0;
  localparam logic [1:0] Y_LO    = 2'd1;
  localparam logic [1:0] Y_HI    = 2'd2;

  localparam logic [3:0] D_NONE = 4'd0;
  localparam logic [3:0] D_A00  = 4'd1;
  localparam logic [3:0] D_A01  = 4'd2;
  localparam logic [3:0] D_A02  = 4'd3;
  localparam logic [3:0] D_A11  = 4'd4;
  localparam logic [3:0] D_A12  = 4'd5;
  localparam logic [3:0] D_A22  = 4'd6;
  localparam logic [3:0] D_DET  = 4'd7;
  localparam logic [3:0] D_P0   = 4'd8;
  localparam logic [3:0] D_P1   = 4'd9;
  localparam logic [3:0] D_P2   = 4'd10;

  typedef struct packed {
    logic [3:0] xsel;
    logic [1:0] ykind;
    logic [3:0] ysmall;
    logic [2:0] ybig;
    logic       neg;
    logic       clr;
    logic [3:0] dest;
  } step_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] det;
    logic signed [ACC_W-1:0] p0;
    logic signed [ACC_W-1:0] p1;
    logic signed [ACC_W-1:0] p2;
    logic                    a22_pos;
  } mac_res_t;

  function automatic step_t mk(input logic [3:0] xs, input logic [1:0] yk,
                               input logic [3:0] ys, input logic [2:0] yb,
                               input logic ng, input logic cl, input logic [3:0] ds);
    step_t st;
    st.xsel = xs; st.ykind = yk; st.ysmall = ys; st.ybig = yb;
    st.neg = ng; st.clr = cl; st.dest = ds;
    return st;
  endfunction

  // adjugate, then det = row 0 of H times adjugate column, then p = adj * g
  function automatic step_t step_of(input logic [STEP_W-1:0] s);
    step_t st;
    st = mk(OP_HUU, Y_SMALL, OP_HUU, AD_00, 1'b0, 1'b1, D_NONE);
    case (s)
      6'd0:  st = mk(OP_HVV, Y_SMALL, OP_HWW, AD_00, 1'b0, 1'b1, D_NONE);
      6'd1:  st = mk(OP_HVW, Y_SMALL, OP_HVW, AD_00, 1'b1, 1'b0, D_A00);
      6'd2:  st = mk(OP_HUW, Y_SMALL, OP_HVW, AD_00, 1'b0, 1'b1, D_NONE);
      6'd3:  st = mk(OP_HUV, Y_SMALL, OP_HWW, AD_00, 1'b1, 1'b0, D_A01);
      6'd4:  st = mk(OP_HUV, Y_SMALL, OP_HVW, AD_00, 1'b0, 1'b1, D_NONE);
      6'd5:  st = mk(OP_HVV, Y_SMALL, OP_HUW, AD_00, 1'b1, 1'b0, D_A02);
      6'd6:  st = mk(OP_HUU, Y_SMALL, OP_HWW, AD_00, 1'b0, 1'b1, D_NONE);
      6'd7:  st = mk(OP_HUW, Y_SMALL, OP_HUW, AD_00, 1'b1, 1'b0, D_A11);
      6'd8:  st = mk(OP_HUV, Y_SMALL, OP_HUW, AD_00, 1'b0, 1'b1, D_NONE);
      6'd9:  st = mk(OP_HUU, Y_SMALL, OP_HVW, AD_00, 1'b1, 1'b0, D_A12);
      6'd10: st = mk(OP_HUU, Y_SMALL, OP_HVV, AD_00, 1'b0, 1'b1, D_NONE);
      6'd11: st = mk(OP_HUV, Y_SMALL, OP_HUV, AD_00, 1'b1, 1'b0, D_A22);
      6'd12: st = mk(OP_HUU, Y_LO, OP_HUU, AD_00, 1'b0, 1'b1, D_NONE);
      6'd13: st = mk(OP_HUU, Y_HI, OP_HUU, AD_00, 1'b0, 1'b0, D_NONE);
      6'd14: st = mk(OP_HUV, Y_LO, OP_HUU, AD_01, 1'b0, 1'b0, D_NONE);
      6'd15: st = mk(OP_HUV, Y_HI, OP_HUU, AD_01, 1'b0, 1'b0, D_NONE);
      6'd16: st = mk(OP_HUW, Y_LO, OP_HUU, AD_02, 1'b0, 1'b0, D_NONE);
      6'd17: st = mk(OP_HUW, Y_HI, OP_HUU, AD_02, 1'b0, 1'b0, D_DET);
      6'd18: st = mk(OP_GU, Y_LO, OP_HUU, AD_00, 1'b0, 1'b1, D_NONE);
      6'd19: st = mk(OP_GU, Y_HI, OP_HUU, AD_00, 1'b0, 1'b0, D_NONE);
      6'd20: st = mk(OP_GV, Y_LO, OP_HUU, AD_01, 1'b0, 1'b0, D_NONE);
      6'd21: st = mk(OP_GV, Y_HI, OP_HUU, AD_01, 1'b0, 1'b0, D_NONE);
      6'd22: st = mk(OP_GW, Y_LO, OP_HUU, AD_02, 1'b0, 1'b0, D_NONE);
      6'd23: st = mk(OP_GW, Y_HI, OP_HUU, AD_02, 1'b0, 1'b0, D_P0);
      6'd24: st = mk(OP_GU, Y_LO, OP_HUU, AD_01, 1'b0, 1'b1, D_NONE);
      6'd25: st = mk(OP_GU, Y_HI, OP_HUU, AD_01, 1'b0, 1'b0, D_NONE);
      6'd26: st = mk(OP_GV, Y_LO, OP_HUU, AD_11, 1'b0, 1'b0, D_NONE);
      6'd27: st = mk(OP_GV, Y_HI, OP_HUU, AD_11, 1'b0, 1'b0, D_NONE);
      6'd28: st = mk(OP_GW, Y_LO, OP_HUU, AD_12, 1'b0, 1'b0, D_NONE);
      6'd29: st = mk(OP_GW, Y_HI, OP_HUU, AD_12, 1'b0, 1'b0, D_P1);
      6'd30: st = mk(OP_GU, Y_LO, OP_HUU, AD_02, 1'b0, 1'b1, D_NONE);
      6'd31: st = mk(OP_GU, Y_HI, OP_HUU, AD_02, 1'b0, 1'b0, D_NONE);
      6'd32: st = mk(OP_GV, Y_LO, OP_HUU, AD_12, 1'b0, 1'b0, D_NONE);
      6'd33: st = mk(OP_GV, Y_HI, OP_HUU, AD_12, 1'b0, 1'b0, D_NONE);
      6'd34: st = mk(OP_GW, Y_LO, OP_HUU, AD_22, 1'b0, 1'b0, D_NONE);
      6'd35: st = mk(OP_GW, Y_HI, OP_HUU, AD_22, 1'b0, 1'b0, D_P2);
      default: st = mk(OP_HUU, Y_SMALL, OP_HUU, AD_00, 1'b0, 1'b1, D_NONE);
    endcase
    return st;
  endfunction

endpackage

[design/qfpo_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module qfpo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/qfpo_mac.sv]
// sequenced multiply-accumulate: adjugate, determinant and adjugate-gradient products
// depends on qfpo_pkg
module qfpo_mac import qfpo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [H_W-1:0] opnd [NOPND],
  output logic                  done,
  output mac_res_t              res
);

  logic                      busy_r;
  logic                      ph_r;
  logic [STEP_W-1:0]         step_r;
  logic                      done_r;
  step_t                     stp_r;
  step_t                     cur;
  logic signed [SEG_W:0]     y;
  logic signed [H_W+SEG_W:0] prod_r;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ADJ_W-1:0]   adj_r [NADJ];
  logic signed [ACC_W-1:0]   det_r;
  logic signed [ACC_W-1:0]   p_r [3];

  assign cur = step_of(step_r);

  always_comb begin
    case (cur.ykind)
      Y_LO:    y = signed'({1'b0, adj_r[cur.ybig][SEG_W-1:0]});
      Y_HI:    y = (SEG_W+1)'(signed'(adj_r[cur.ybig][ADJ_W-1:SEG_W]));
      default: y = (SEG_W+1)'(opnd[cur.ysmall]);
    endcase
  end

  always_comb begin
    term = ACC_W'(prod_r);
    if (stp_r.ykind == Y_HI) begin
      term = term <<< SEG_W;
    end
    if (stp_r.neg) begin
      term = -term;
    end
    acc_nxt = (stp_r.clr ? '0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 1'b0;
        step_r <= '0;
      end else if (busy_r) begin
        ph_r <= ~ph_r;
        if (ph_r) begin
          if (step_r == STEP_W'(NSTEP - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
      end
    end
  end

  // multiply on phase 0, accumulate on phase 1
  always_ff @(posedge clk) begin
    if (busy_r && !ph_r) begin
      prod_r <= opnd[cur.xsel] * y;
      stp_r  <= cur;
    end
    if (busy_r && ph_r) begin
      acc_r <= acc_nxt;
      case (stp_r.dest)
        D_A00:   adj_r[AD_00] <= acc_nxt[ADJ_W-1:0];
        D_A01:   adj_r[AD_01] <= acc_nxt[ADJ_W-1:0];
        D_A02:   adj_r[AD_02] <= acc_nxt[ADJ_W-1:0];
        D_A11:   adj_r[AD_11] <= acc_nxt[ADJ_W-1:0];
        D_A12:   adj_r[AD_12] <= acc_nxt[ADJ_W-1:0];
        D_A22:   adj_r[AD_22] <= acc_nxt[ADJ_W-1:0];
        D_DET:   det_r <= acc_nxt;
        D_P0:    p_r[0] <= acc_nxt;
        D_P1:    p_r[1] <= acc_nxt;
        D_P2:    p_r[2] <= acc_nxt;
        default: ;
      endcase
    end
  end

  assign done        = done_r;
  assign res.det     = det_r;
  assign res.p0      = p_r[0];
  assign res.p1      = p_r[1];
  assign res.p2      = p_r[2];
  assign res.a22_pos = !adj_r[AD_22][ADJ_W-1] && (adj_r[AD_22] != '0);

endmodule

[design/qfpo_div.sv]
// restoring divider, one quotient bit per cycle, with offset limit check
// depends on qfpo_pkg
module qfpo_div import qfpo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] num,
  input  logic [ACC_W-1:0] den,
  input  logic [LIM_W-1:0] lim,
  output logic             done,
  output logic [Q_W-1:0]   q,
  output logic             beyond
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsh_r;
  logic [Q_W:0]     q_r;
  logic             ge;
  logic [Q_W-1:0]   lim_ext;

  assign ge      = rem_r >= dsh_r;
  assign lim_ext = {1'b0, lim};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // first step tests for a quotient of 2^16 or more
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {{(DIV_W-ACC_W-OFF_FRAC){1'b0}}, num, {OFF_FRAC{1'b0}}};
      dsh_r <= {den, {Q_W{1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[Q_W-1:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done   = done_r;
  assign q      = q_r[Q_W-1:0];
  assign beyond = q_r[Q_W] || (q_r[Q_W-1:0] > lim_ext) ||
                  ((q_r[Q_W-1:0] == lim_ext) && (rem_r != '0));

endmodule

[design/quad_fit_peak_offset_3d.sv]
// top level of the 3x3x3 quadratic sub-sample peak fit
// depends on qfpo_pkg, qfpo_ram, qfpo_mac, qfpo_div and the assertion macro header
//
// Samples of a 3x3x3 neighbourhood are written one word per cycle while no fit is
// running, into a 27-entry ram at position u*9+v*3+w; every position must be written
// before the fit uses it. A word with last_sample set stores its sample and then
// starts the fit: the ram is swept once to build slice and corner sums, the scaled
// gradient and Hessian are formed, a single shared 24x25 multiplier with a 76-bit
// accumulator runs 36 multiply-accumulate steps for the adjugate, determinant and
// adjugate-gradient products, and a one-bit-per-cycle restoring divider produces each
// of the three offsets. A non-final word leaves the input side ready for the next; a
// final word keeps the input side busy until the fit is rejected or all three offsets
// are divided, and longer while the previous result word has not been taken. The
// result word waits in an output register, so loading of the next neighbourhood can
// start before it is taken.
// Status 1 means the Hessian is not negative definite, 2 that |det| is too small
// against det_min (2^-30 units), 3 that some offset exceeds disp_limit; all three
// offsets read zero on any rejection. Offsets are signed Q3.12, truncated toward zero.
`include "quad_fit_peak_offset_3d_macros.svh"

module quad_fit_peak_offset_3d import qfpo_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ADDR_W-1:0]       in_sample_index,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                    in_last_sample,
  // result words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [Q_W-1:0]   out_offset_u,
  output logic signed [Q_W-1:0]   out_offset_v,
  output logic signed [Q_W-1:0]   out_offset_w,
  output logic [1:0]              out_fit_status,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DMIN_W-1:0]       cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_HG    = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]              state_r;

  // configuration
  logic [DMIN_W-1:0]       det_min_r;
  logic [LIM_W-1:0]        disp_limit_r;
  logic [DSC_W-1:0]        dmin_scaled_r;

  // ram sweep
  logic                    in_acc;
  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       rd_addr_r;
  logic                    rd_vld_r;
  logic [SAMPLE_BITS-1:0]  ram_rdata;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [1:0]              u_r;
  logic [1:0]              v_r;
  logic [1:0]              w_r;
  logic                    sweep_last;

  // slice sums and corner sums (corner index {first==2, second==2})
  logic signed [SUM_W-1:0] su_r [3];
  logic signed [SUM_W-1:0] sv_r [3];
  logic signed [SUM_W-1:0] sw_r [3];
  logic signed [CRN_W-1:0] cuv_r [4];
  logic signed [CRN_W-1:0] cuw_r [4];
  logic signed [CRN_W-1:0] cvw_r [4];

  logic signed [H_W-1:0]   ops_nxt [NOPND];
  logic signed [H_W-1:0]   opnd_r [NOPND];
  logic signed [H_W-1:0]   tuv;
  logic signed [H_W-1:0]   tuw;
  logic signed [H_W-1:0]   tvw;

  logic                    mac_go_r;
  logic                    mac_done;
  mac_res_t                mac_res;

  // fit checks
  logic [ACC_W-1:0]        dabs;
  logic                    neg_def;
  logic                    det_ok;
  logic [DET_FRAC+18:0]    dabs_low_sh;

  logic                    div_go_r;
  logic [1:0]              axis_r;
  logic signed [ACC_W-1:0] p_sel;
  logic [ACC_W-1:0]        p_abs;
  logic                    div_done;
  logic [Q_W-1:0]          div_q;
  logic                    div_beyond;

  logic signed [Q_W-1:0]   off_r [3];
  logic [1:0]              status_r;

  logic                    out_valid_r;
  logic signed [Q_W-1:0]   out_u_r;
  logic signed [Q_W-1:0]   out_v_r;
  logic signed [Q_W-1:0]   out_w_r;
  logic [1:0]              out_st_r;
  logic                    out_free;

  // nothing is taken while reset is held
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // writes to positions 27..31 are dropped
  assign ram_we = in_acc && (in_sample_index < ADDR_W'(NPOS));
  assign ram_re = (state_r == S_SWEEP) && (rd_addr_r != ADDR_W'(NPOS));

  // the final write is in the ram by the time the sweep reads position 0, so no forwarding
  qfpo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NPOS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_sample_index),
    .wdata (in_sample_value),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign smp        = signed'(ram_rdata);
  assign sweep_last = rd_vld_r && (u_r == 2'd2) && (v_r == 2'd2) && (w_r == 2'd2);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_min_r    <= DMIN_W'(1074);
      disp_limit_r <= LIM_W'(8192);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DET_MIN:    det_min_r    <= cfg_data;
        CFG_DISP_LIMIT: disp_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // det_min * 6^6, held in a register
  always_ff @(posedge clk) begin
    dmin_scaled_r <= DSC_W'(det_min_r * 16'(DET_SCALE));
  end

  // sweep read pointer and neighbourhood position of returning data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_sample) begin
      rd_addr_r <= '0;
      u_r <= '0;
      v_r <= '0;
      w_r <= '0;
      for (int i = 0; i < 3; i++) begin
        su_r[i] <= '0;
        sv_r[i] <= '0;
        sw_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        cuv_r[i] <= '0;
        cuw_r[i] <= '0;
        cvw_r[i] <= '0;
      end
    end else begin
      if (ram_re) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (rd_vld_r) begin
        su_r[u_r] <= su_r[u_r] + SUM_W'(smp);
        sv_r[v_r] <= sv_r[v_r] + SUM_W'(smp);
        sw_r[w_r] <= sw_r[w_r] + SUM_W'(smp);
        if (u_r != 2'd1 && v_r != 2'd1) begin
          cuv_r[{u_r[1], v_r[1]}] <= cuv_r[{u_r[1], v_r[1]}] + CRN_W'(smp);
        end
        if (u_r != 2'd1 && w_r != 2'd1) begin
          cuw_r[{u_r[1], w_r[1]}] <= cuw_r[{u_r[1], w_r[1]}] + CRN_W'(smp);
        end
        if (v_r != 2'd1 && w_r != 2'd1) begin
          cvw_r[{v_r[1], w_r[1]}] <= cvw_r[{v_r[1], w_r[1]}] + CRN_W'(smp);
        end
        if (w_r == 2'd2) begin
          w_r <= '0;
          if (v_r == 2'd2) begin
            v_r <= '0;
            u_r <= u_r + 1'b1;
          end else begin
            v_r <= v_r + 1'b1;
          end
        end else begin
          w_r <= w_r + 1'b1;
        end
      end
    end
  end

  // gradient and hessian scaled by 36
  always_comb begin
    tuv = H_W'(cuv_r[3]) + H_W'(cuv_r[0]) - H_W'(cuv_r[2]) - H_W'(cuv_r[1]);
    tuw = H_W'(cuw_r[3]) + H_W'(cuw_r[0]) - H_W'(cuw_r[2]) - H_W'(cuw_r[1]);
    tvw = H_W'(cvw_r[3]) + H_W'(cvw_r[0]) - H_W'(cvw_r[2]) - H_W'(cvw_r[1]);
    ops_nxt[OP_HUU] = (H_W'(su_r[2]) + H_W'(su_r[0]) - (H_W'(su_r[1]) <<< 1)) <<< 2;
    ops_nxt[OP_HVV] = (H_W'(sv_r[2]) + H_W'(sv_r[0]) - (H_W'(sv_r[1]) <<< 1)) <<< 2;
    ops_nxt[OP_HWW] = (H_W'(sw_r[2]) + H_W'(sw_r[0]) - (H_W'(sw_r[1]) <<< 1)) <<< 2;
    ops_nxt[OP_HUV] = (tuv <<< 1) + tuv;
    ops_nxt[OP_HUW] = (tuw <<< 1) + tuw;
    ops_nxt[OP_HVW] = (tvw <<< 1) + tvw;
    ops_nxt[OP_GU]  = (H_W'(su_r[2]) - H_W'(su_r[0])) <<< 1;
    ops_nxt[OP_GV]  = (H_W'(sv_r[2]) - H_W'(sv_r[0])) <<< 1;
    ops_nxt[OP_GW]  = (H_W'(sw_r[2]) - H_W'(sw_r[0])) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HG) begin
      opnd_r <= ops_nxt;
    end
  end

  qfpo_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_go_r),
    .opnd  (opnd_r),
    .done  (mac_done),
    .res   (mac_res)
  );

  // negative definite: huu < 0, leading 2x2 minor > 0, det < 0
  assign neg_def = opnd_r[OP_HUU][H_W-1] && mac_res.a22_pos && mac_res.det[ACC_W-1];
  assign dabs    = ACC_W'(-mac_res.det);
  // |det| * 2^30 > det_min * 46656; any bit at 2^19 or above passes outright
  assign dabs_low_sh = {dabs[18:0], {DET_FRAC{1'b0}}};
  assign det_ok  = (dabs[ACC_W-1:19] != '0) ||
                   (dabs_low_sh > (DET_FRAC+19)'(dmin_scaled_r));

  always_comb begin
    case (axis_r)
      2'd1:    p_sel = mac_res.p1;
      2'd2:    p_sel = mac_res.p2;
      default: p_sel = mac_res.p0;
    endcase
    p_abs = p_sel[ACC_W-1] ? ACC_W'(-p_sel) : ACC_W'(p_sel);
  end

  qfpo_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_go_r),
    .num    (p_abs),
    .den    (dabs),
    .lim    (disp_limit_r),
    .done   (div_done),
    .q      (div_q),
    .beyond (div_beyond)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mac_go_r <= 1'b0;
      div_go_r <= 1'b0;
      axis_r   <= '0;
    end else begin
      mac_go_r <= 1'b0;
      div_go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_last_sample) begin
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (sweep_last) begin
            state_r <= S_HG;
          end
        end
        S_HG: begin
          mac_go_r <= 1'b1;
          state_r  <= S_MAC;
        end
        S_MAC: begin
          if (mac_done) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          axis_r <= '0;
          if (neg_def && det_ok) begin
            div_go_r <= 1'b1;
            state_r  <= S_DIV;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_beyond || axis_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              axis_r   <= axis_r + 1'b1;
              div_go_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // offsets and status of the fit in progress
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
      if (!neg_def) begin
        status_r <= ST_NOT_NEG;
      end else if (!det_ok) begin
        status_r <= ST_DET_SMALL;
      end else begin
        status_r <= ST_OK;
      end
    end else if (state_r == S_DIV && div_done) begin
      if (div_beyond) begin
        status_r <= ST_BEYOND;
        off_r[0] <= '0;
        off_r[1] <= '0;
        off_r[2] <= '0;
      end else begin
        off_r[axis_r] <= p_sel[ACC_W-1] ? -signed'(div_q) : signed'(div_q);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_u_r  <= off_r[0];
      out_v_r  <= off_r[1];
      out_w_r  <= off_r[2];
      out_st_r <= status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_offset_u   = out_u_r;
  assign out_offset_v   = out_v_r;
  assign out_offset_w   = out_w_r;
  assign out_fit_status = out_st_r;

  `QFPO_ASSERT_NOW(a_mac_done_in_mac, mac_done, state_r == S_MAC, "mac finished outside its phase")
  `QFPO_ASSERT_NOW(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside its phase")
  `QFPO_ASSERT_NEXT(a_hold_when_full, (state_r == S_DONE) && out_valid_r && !out_ready, state_r == S_DONE, "result dropped while output word pending")
  `QFPO_ASSERT_NOW(a_reject_zero, out_valid_r && (out_st_r != ST_OK), (out_u_r == '0) && (out_v_r == '0) && (out_w_r == '0), "rejected fit carries nonzero offsets")
  `QFPO_ASSERT_NEXT(a_sweep_start, in_acc && in_last_sample, (state_r == S_SWEEP) && (rd_addr_r == '0), "sweep did not start at position zero")

endmodule
